[rtl/assert_macros.svh]
// Assertion helpers; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define TPCMP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("tpcmp assertion failed");

`define TPCMP_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("tpcmp forbidden condition seen");

`else

`define TPCMP_ASSERT(lbl, clk, rstn, prop)

`define TPCMP_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

[rtl/tpcmp_pkg.sv]
`default_nettype none

package tpcmp_pkg;

    localparam int DUTY_W     = 16;
    localparam int CMP_W      = 16;
    localparam int NUM_STAGES = 4;
    localparam int CFG_IDX_W  = 4;

    localparam logic signed [DUTY_W:0] Q_ONE     = 17'sd16384;
    localparam logic signed [DUTY_W:0] Q_NEG_ONE = -17'sd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_MAX = 4'd0,
        CFG_MIN_PULSE  = 4'd1
    } cfg_idx_t;

    // per-stage load strobes from the pipeline control to the lanes
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

[rtl/tpcmp_ctrl.sv]
`default_nettype none

`include "assert_macros.svh"

module tpcmp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tpcmp_pkg::pipe_ctrl_t  pipe_ctrl
);
    import tpcmp_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] rdy;

    always_comb begin
        rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (rdy[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (rdy[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready        = rdy[0];
    assign m_valid        = valid_reg[NUM_STAGES-1];
    assign pipe_ctrl.load = rdy;

    // empty output stage means the whole chain can move
    `TPCMP_ASSERT(a_empty_out_takes, aclk, aresetn, !m_valid |-> s_ready)
    // a beat leaving the last inner stage lands in the output stage
    `TPCMP_ASSERT(a_no_drop, aclk, aresetn,
                  (valid_reg[NUM_STAGES-2] && rdy[NUM_STAGES-1]) |=> m_valid)
    // a held first-stage beat is not lost while stalled
    `TPCMP_ASSERT(a_hold_s0, aclk, aresetn, (valid_reg[0] && !rdy[0]) |=> valid_reg[0])
    // the stage-1 load strobe never fires while that stage's beat is stuck
    `TPCMP_ASSERT_NEVER(a_load_on_stall, aclk, aresetn,
                        pipe_ctrl.load[1] && valid_reg[1] && !rdy[2])

endmodule

`default_nettype wire

[rtl/tpcmp_lane.sv]
`default_nettype none

module tpcmp_lane (
    input  wire logic                               aclk,
    input  wire tpcmp_pkg::pipe_ctrl_t              pipe_ctrl,
    input  wire logic [tpcmp_pkg::CMP_W-1:0]        period,
    input  wire logic [tpcmp_pkg::CMP_W-1:0]        min_width,
    input  wire logic signed [tpcmp_pkg::DUTY_W-1:0] duty,
    output logic [tpcmp_pkg::CMP_W-1:0]             compare
);
    import tpcmp_pkg::*;

    logic signed [DUTY_W:0]   duty_ext;
    logic signed [DUTY_W:0]   duty_clamped;
    logic signed [DUTY_W:0]   a_wide;
    logic [DUTY_W-1:0]        a_reg;
    logic [CMP_W-1:0]         pm1;
    logic [2*CMP_W-1:0]       prod_reg;
    logic [CMP_W-1:0]         v;
    logic [CMP_W-1:0]         half;
    logic signed [CMP_W+1:0]  sv;
    logic signed [CMP_W+1:0]  sh;
    logic signed [CMP_W+1:0]  sm;
    logic signed [CMP_W+1:0]  sp_h;
    logic signed [CMP_W+1:0]  sp_m;
    logic [CMP_W-1:0]         v_reg;
    logic                     lt_h_reg;
    logic                     mid_lo_reg;
    logic                     gt_ph_reg;
    logic                     mid_hi_reg;
    logic [CMP_W-1:0]         cmp_next;
    logic [CMP_W-1:0]         cmp_reg;

    // stage 1: clamp to +/-1.0 and form 1 - t
    always_comb begin
        duty_ext = (DUTY_W+1)'(duty);
        if (duty_ext > Q_ONE) begin
            duty_clamped = Q_ONE;
        end else if (duty_ext < Q_NEG_ONE) begin
            duty_clamped = Q_NEG_ONE;
        end else begin
            duty_clamped = duty_ext;
        end
        a_wide = Q_ONE - duty_clamped;
    end

    always_ff @(posedge aclk) begin
        if (pipe_ctrl.load[0]) begin
            a_reg <= a_wide[DUTY_W-1:0];
        end
    end

    // stage 2: scale by period - 1
    assign pm1 = (period != '0) ? period - CMP_W'(1) : '0;

    always_ff @(posedge aclk) begin
        if (pipe_ctrl.load[1]) begin
            prod_reg <= (2*CMP_W)'(a_reg) * (2*CMP_W)'(pm1);
        end
    end

    // stage 3: divide by 32768 and compare against pulse limits
    assign v    = prod_reg[30:15];
    assign half = {1'b0, min_width[CMP_W-1:1]};
    assign sv   = $signed({2'b00, v});
    assign sh   = $signed({2'b00, half});
    assign sm   = $signed({2'b00, min_width});
    assign sp_h = $signed({2'b00, period}) - sh;
    assign sp_m = $signed({2'b00, period}) - sm;

    always_ff @(posedge aclk) begin
        if (pipe_ctrl.load[2]) begin
            v_reg      <= v;
            lt_h_reg   <= sv < sh;
            mid_lo_reg <= (sv > sh) && (sv < sm);
            gt_ph_reg  <= sv > sp_h;
            mid_hi_reg <= (sv < sp_h) && (sv > sp_m);
        end
    end

    // stage 4: apply short-pulse rules in priority order
    always_comb begin
        if (lt_h_reg) begin
            cmp_next = '0;
        end else if (mid_lo_reg) begin
            cmp_next = min_width;
        end else if (gt_ph_reg) begin
            cmp_next = period;
        end else if (mid_hi_reg) begin
            cmp_next = period - min_width;
        end else begin
            cmp_next = v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ctrl.load[3]) begin
            cmp_reg <= cmp_next;
        end
    end

    assign compare = cmp_reg;

endmodule

`default_nettype wire

[rtl/three_phase_compare_with_min_pulse_core.sv]
`default_nettype none

// Channel   Ports                                    Dir
// s_        s_valid/s_ready, s_duty_u/v/w            in
// m_        m_valid/m_ready, m_compare_u/v/w         out
// cfg_      cfg_valid/cfg_ready, cfg_index, cfg_data in
//
// Four-stage pipeline: clamp, multiply, limit compare, select.
// One beat per cycle unless m_ready stalls the output; an accepted beat
// passes the stage registers in order and m_valid rises at the last one.
// Reset is synchronous on aresetn; it clears stage valids and loads
// period_max = all ones, min_pulse_ticks = 0. No clearing pass.
// A stall on m_ready backs up stage by stage; bubbles still fill.
module three_phase_compare_with_min_pulse_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [tpcmp_pkg::DUTY_W-1:0]  s_duty_u,
    input  wire logic signed [tpcmp_pkg::DUTY_W-1:0]  s_duty_v,
    input  wire logic signed [tpcmp_pkg::DUTY_W-1:0]  s_duty_w,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [tpcmp_pkg::CMP_W-1:0]               m_compare_u,
    output logic [tpcmp_pkg::CMP_W-1:0]               m_compare_v,
    output logic [tpcmp_pkg::CMP_W-1:0]               m_compare_w,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tpcmp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tpcmp_pkg::CMP_W-1:0]          cfg_data
);
    import tpcmp_pkg::*;

    localparam int REG_W = (COUNT_WIDTH < CMP_W) ? COUNT_WIDTH : CMP_W;

    logic [REG_W-1:0] period_reg;
    logic [REG_W-1:0] period_next;
    logic [REG_W-1:0] min_width_reg;
    logic [REG_W-1:0] min_width_next;
    logic [CMP_W-1:0] period;
    logic [CMP_W-1:0] min_width;
    pipe_ctrl_t       pipe_ctrl;

    assign cfg_ready = 1'b1;

    always_comb begin
        period_next    = period_reg;
        min_width_next = min_width_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PERIOD_MAX: period_next    = cfg_data[REG_W-1:0];
                CFG_MIN_PULSE:  min_width_next = cfg_data[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= '1;
            min_width_reg <= '0;
        end else begin
            period_reg    <= period_next;
            min_width_reg <= min_width_next;
        end
    end

    assign period    = CMP_W'(period_reg);
    assign min_width = CMP_W'(min_width_reg);

    tpcmp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .pipe_ctrl (pipe_ctrl)
    );

    tpcmp_lane u_lane_u (
        .aclk      (aclk),
        .pipe_ctrl (pipe_ctrl),
        .period    (period),
        .min_width (min_width),
        .duty      (s_duty_u),
        .compare   (m_compare_u)
    );

    tpcmp_lane u_lane_v (
        .aclk      (aclk),
        .pipe_ctrl (pipe_ctrl),
        .period    (period),
        .min_width (min_width),
        .duty      (s_duty_v),
        .compare   (m_compare_v)
    );

    tpcmp_lane u_lane_w (
        .aclk      (aclk),
        .pipe_ctrl (pipe_ctrl),
        .period    (period),
        .min_width (min_width),
        .duty      (s_duty_w),
        .compare   (m_compare_w)
    );

endmodule

`default_nettype wire

[test/tb_three_phase_compare_with_min_pulse_core.sv]
`default_nettype none

module tb_three_phase_compare_with_min_pulse_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tpcmp_pkg::*;

    localparam int                   COUNT_WIDTH  = 16;
    localparam int                   QUIET_LIMIT  = 2000;
    localparam int                   PIPE_LATENCY = 4;
    localparam int                   PHASE_ITEMS  = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 4'd9;

    typedef logic signed [DUTY_W-1:0] duty_t;
    typedef logic [CMP_W-1:0]         count_t;

    typedef struct packed {
        count_t u;
        count_t v;
        count_t w;
    } compare_set_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    duty_t                s_duty_u  = '0;
    duty_t                s_duty_v  = '0;
    duty_t                s_duty_w  = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    count_t               m_compare_u;
    count_t               m_compare_v;
    count_t               m_compare_w;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PERIOD_MAX;
    count_t               cfg_data  = '0;

    compare_set_t pending_compares[$];
    count_t       period_cfg;
    count_t       min_width_cfg;
    int           fail_count = 0;
    bit           no_idle    = 1'b0;

    three_phase_compare_with_min_pulse_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_duty_u   (s_duty_u),
        .s_duty_v   (s_duty_v),
        .s_duty_w   (s_duty_w),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_compare_u(m_compare_u),
        .m_compare_v(m_compare_v),
        .m_compare_w(m_compare_w),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic count_t compare_value(duty_t duty, count_t per, count_t min_width);
        longint t, p, m, h, pm1, a, v;
        t   = duty;
        p   = per;
        m   = min_width;
        h   = m / 2;
        pm1 = (p > 0) ? p - 1 : 0;
        if (t > longint'(Q_ONE))
            t = Q_ONE;
        else if (t < longint'(Q_NEG_ONE))
            t = Q_NEG_ONE;
        a = longint'(Q_ONE) - t;
        v = (a * pm1) / (2 * longint'(Q_ONE));
        if (v < h)
            v = 0;
        else if (v > h && v < m)
            v = m;
        else if (v > p - h)
            v = p;
        else if (v < p - h && v > p - m)
            v = p - m;
        return count_t'(v);
    endfunction

    // register shadow and expected compare sets, updated on accepted beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            period_cfg    = '1;
            min_width_cfg = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_PERIOD_MAX)
                    period_cfg = cfg_data;
                else if (cfg_index == CFG_MIN_PULSE)
                    min_width_cfg = cfg_data;
            end
            if (s_valid && s_ready) begin
                pending_compares.push_back('{
                    u: compare_value(s_duty_u, period_cfg, min_width_cfg),
                    v: compare_value(s_duty_v, period_cfg, min_width_cfg),
                    w: compare_value(s_duty_w, period_cfg, min_width_cfg)});
            end
        end
    end

    task automatic check_field(string name, count_t expected, count_t actual);
        if (expected !== actual) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t %s mismatch: expected %0d, got %0d", $realtime, name,
                         expected, actual);
        end
    endtask

    always @(posedge aclk) begin
        compare_set_t exp_set;
        if (aresetn && m_valid && m_ready) begin
            if (pending_compares.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t unexpected result beat: %0d %0d %0d", $realtime,
                             m_compare_u, m_compare_v, m_compare_w);
            end else begin
                exp_set = pending_compares.pop_front();
                check_field("compare_u", exp_set.u, m_compare_u);
                check_field("compare_v", exp_set.v, m_compare_v);
                check_field("compare_w", exp_set.w, m_compare_w);
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 38);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic send_duty(duty_t u, duty_t v, duty_t w);
        while (!no_idle && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_duty_u <= u;
        s_duty_v <= v;
        s_duty_w <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait until every expected compare set is back, then let the pipe go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_compares.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, count_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // the spare index write must leave both registers alone
    task automatic configure(count_t per, count_t min_width);
        write_reg(CFG_PERIOD_MAX, per);
        write_reg(CFG_MIN_PULSE, min_width);
        write_reg(CFG_SPARE, count_t'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic duty_t random_duty();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return duty_t'(int'($urandom_range(2 * int'(Q_ONE))) - int'(Q_ONE));
        else if (pick < 60)
            case ($urandom_range(3))
                0: return duty_t'(Q_ONE);
                1: return duty_t'(Q_NEG_ONE);
                2: return 16'sh7fff;
                default: return 16'sh8000;
            endcase
        else
            return duty_t'($urandom);
    endfunction

    task automatic test_reset_config();
        send_duty(duty_t'(Q_ONE), duty_t'(Q_NEG_ONE), 16'sd0);
        send_duty(16'sh7fff, 16'sh8000, 16'sd1);
        send_duty(16'sd16385, -16'sd16385, -16'sd1);
        send_duty(16'sh5555, 16'shaaaa, 16'sh2aaa);
        send_duty(16'sd0, duty_t'(Q_ONE), 16'sh8000);
        send_duty(-16'sd16383, 16'sd16383, 16'sh7fff);
        send_duty(16'shd555, 16'sd8192, -16'sd8192);
        send_duty(16'sd100, 16'sh4001, 16'shbfff);
        settle();
    endtask

    // P = 12, m = 4: one item per raw value 0..11 walks through every band edge
    task automatic test_short_pulse_bands();
        int pm1, a_u, a_w;
        configure(16'd12, 16'd4);
        pm1 = 11;
        for (int raw = 0; raw <= pm1; raw++) begin
            a_u = (raw * 32768 + pm1 - 1) / pm1;
            a_w = ((pm1 - raw) * 32768 + pm1 - 1) / pm1;
            send_duty(duty_t'(int'(Q_ONE) - a_u), random_duty(),
                      duty_t'(int'(Q_ONE) - a_w));
        end
        settle();
    endtask

    task automatic test_period_extremes();
        configure(16'd0, 16'd2);
        send_duty(duty_t'(Q_NEG_ONE), duty_t'(Q_ONE), 16'sh8000);
        settle();
        configure(16'd0, 16'd0);
        send_duty(16'sh8000, 16'sd0, 16'sh7fff);
        settle();
        configure(16'd1, 16'hffff);
        send_duty(duty_t'(Q_NEG_ONE), 16'sd0, duty_t'(Q_ONE));
        settle();
    endtask

    task automatic test_random_phases();
        count_t per, min_width;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin per = '1;                        min_width = '0;       end
                1: begin per = '1;                        min_width = 16'hfffe; end
                2: begin per = '1;                        min_width = '1;       end
                3: begin per = count_t'($urandom_range(2, 40));
                         min_width = count_t'($urandom_range(0, per + 4)); end
                4: begin per = count_t'($urandom_range(2, 40));
                         min_width = count_t'($urandom_range(0, per)) | 16'd1; end
                5: begin per = count_t'($urandom_range(1, 300));
                         min_width = count_t'($urandom_range(0, 64)); end
                6: begin per = count_t'($urandom_range(100, 65535));
                         min_width = count_t'($urandom_range(0, 200)) & 16'hfffe; end
                default: begin per = count_t'($urandom); min_width = count_t'($urandom); end
            endcase
            configure(per, min_width);
            no_idle = (phase == 7);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_duty(random_duty(), random_duty(), random_duty());
            settle();
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_config();
        test_short_pulse_bands();
        test_period_extremes();
        test_random_phases();
        if (fail_count == 0 && pending_compares.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
